// ===== hw/rtl/citl_pkg.sv =====
package citl_pkg;

    localparam int MaxRows     = 64;
    localparam int MaxPoints   = 1024;
    localparam int RowW        = 6;
    localparam int ColW        = 10;
    localparam int AddrW       = RowW + ColW;
    localparam int FracOne     = 65536;

    localparam logic [1:0] StQueryOk  = 2'd0;
    localparam logic [1:0] StRowBad   = 2'd1;
    localparam logic [1:0] StWriteOk  = 2'd2;
    localparam logic [1:0] StWriteBad = 2'd3;

    localparam logic       CmdWrite = 1'b0;
    localparam logic       CmdQuery = 1'b1;

    localparam logic [0:0] RegRows   = 1'd0;
    localparam logic [0:0] RegPoints = 1'd1;

    typedef struct packed {
        logic        command;
        logic [5:0]  row;
        logic [9:0]  column;
        logic [31:0] grid_wave;
        logic [31:0] width_in;
        logic [31:0] shape_in;
        logic [31:0] asym_in;
        logic [31:0] norm_in;
        logic [31:0] query_wave;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] width_out;
        logic [31:0] shape_out;
        logic [31:0] asym_out;
        logic [31:0] norm_out;
    } t_out_word;

    typedef struct packed {
        logic [31:0] width_v;
        logic [31:0] shape_v;
        logic [31:0] asym_v;
        logic [31:0] norm_v;
    } t_vals;

endpackage

// ===== hw/rtl/citl_div.sv =====
module citl_div
    import citl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [16:0] o_quo
);
    // restoring divide of (num << 16) / den, num <= den, 17 quotient bits
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [16:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [33:0] w_sh;

    // first step compares without a shift
    assign w_sh = (r_cnt == 5'd17) ? {1'b0, r_rem} : {r_rem, 1'b0};

    always_comb begin
        if (w_sh >= {2'b0, r_den}) begin
            n_rem = 33'(w_sh - {2'b0, r_den});
        end else begin
            n_rem = w_sh[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd17;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quo  <= 17'd0;
            end else if (r_busy) begin
                // first step yields the bit of weight 2^16
                r_rem <= n_rem;
                r_quo <= {r_quo[15:0], (w_sh >= {2'b0, r_den})};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== hw/rtl/clamped_interp_table_lookup_top.sv =====
// a write passes S_RD and S_OUT; a clamped query ends after reading column 0 or the last column
// one word at a time: the binary search reads the grid memory one probe per S_PROBE and
// S_PAIR pass, then a 17 step divider and one blend multiply per value follow
// reset (synchronous, active low) clears control and registers to 64 rows, 1024 points
// table memories are undefined until written, no clearing pass
module clamped_interp_table_lookup_top
    import citl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_FIRST = 9'b000000100,
        S_LAST  = 9'b000001000,
        S_PROBE = 9'b000010000,
        S_PAIR  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    logic [6:0]  r_rows;
    logic [10:0] r_pts;
    logic [6:0]  w_rows;
    logic [10:0] w_pts;

    logic [31:0] grid_mem [MaxRows*MaxPoints];
    t_vals       val_mem  [MaxRows*MaxPoints];
    logic [31:0] r_grid_q;
    t_vals       r_val_q;
    logic [AddrW-1:0] w_addr;
    logic        w_we;

    t_in_word    r_in;
    logic [10:0] r_lo, r_hi, r_mid;
    t_vals       r_v0, r_v1;
    logic [31:0] r_g0;
    logic [16:0] r_frac;
    logic [1:0]  r_lane;
    logic        r_sel1;
    t_vals       r_res;
    logic        r_ovalid;
    t_out_word   r_out;
    logic        r_div_go;
    logic        w_div_done;
    logic [16:0] w_quo;
    logic [31:0] w_a, w_b;
    logic signed [49:0] r_prod;
    logic        r_mul_v;
    logic [1:0]  r_mul_lane;
    logic signed [49:0] w_sum;
    logic signed [33:0] w_q;
    logic [31:0] w_sat;

    assign w_rows = (r_rows == 7'd0) ? 7'd1 : (r_rows > 7'(MaxRows)) ? 7'(MaxRows) : r_rows;
    assign w_pts  = (r_pts < 11'd2) ? 11'd2 : (r_pts > 11'(MaxPoints)) ? 11'(MaxPoints) : r_pts;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_pts  <= 11'd1024;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegRows:   r_rows <= i_cfg_data[6:0];
                RegPoints: r_pts  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_addr = {r_in.row, r_mid[ColW-1:0]};
        w_we   = 1'b0;
        if (r_state == S_RD && r_in.command == CmdWrite && {1'b0, r_in.row} < w_rows
                && {1'b0, r_in.column} < w_pts) begin
            w_we   = 1'b1;
            w_addr = {r_in.row, r_in.column};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            grid_mem[w_addr] <= r_in.grid_wave;
            val_mem[w_addr]  <= '{r_in.width_in, r_in.shape_in, r_in.asym_in, r_in.norm_in};
        end
        r_grid_q <= grid_mem[w_addr];
        r_val_q  <= val_mem[w_addr];
    end

    citl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_grid_q - r_in.query_wave),
        .i_den   (r_grid_q - r_g0),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        case (r_lane)
            2'd0: begin w_a = r_v0.width_v; w_b = r_v1.width_v; end
            2'd1: begin w_a = r_v0.shape_v; w_b = r_v1.shape_v; end
            2'd2: begin w_a = r_v0.asym_v;  w_b = r_v1.asym_v;  end
            default: begin w_a = r_v0.norm_v; w_b = r_v1.norm_v; end
        endcase
    end

    // v0*f + v1*(1-f) = v1 + (v0-v1)*f
    always_ff @(posedge i_clk) begin
        r_prod <= 50'(($signed({w_a[31], w_a}) - $signed({w_b[31], w_b}))
                  * $signed({1'b0, r_frac})) + 50'($signed(w_b) * 64'sd65536);
    end

    assign w_sum = r_prod;
    assign w_q   = 34'(w_sum >>> 16);
    assign w_sat = (w_q > 34'sd2147483647) ? 32'h7fffffff :
                   (w_q < -34'sd2147483648) ? 32'h80000000 : w_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
            r_mul_v  <= 1'b0;
            r_sel1   <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in    <= i_data;
                        r_mid   <= 11'd0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_in.command == CmdWrite) begin
                        r_out   <= '{status: (w_we ? StWriteOk : StWriteBad), default: '0};
                        r_state <= S_OUT;
                    end else if ({1'b0, r_in.row} >= w_rows) begin
                        r_out   <= '{status: StRowBad, default: '0};
                        r_state <= S_OUT;
                    end else begin
                        r_out   <= '0;
                        r_state <= S_FIRST;
                        r_mid   <= w_pts - 11'd1;
                    end
                end
                S_FIRST: begin
                    // data of column 0 is present
                    if (r_in.query_wave < r_grid_q) begin
                        r_res   <= r_val_q;
                        r_state <= S_OUT;
                    end else begin
                        r_g0    <= r_grid_q;
                        r_v0    <= r_val_q;
                        r_lo    <= 11'd0;
                        r_hi    <= w_pts - 11'd1;
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    if (r_in.query_wave >= r_grid_q) begin
                        r_res   <= r_val_q;
                        r_state <= S_OUT;
                    end else if (r_hi - r_lo <= 11'd1) begin
                        r_v1     <= r_val_q;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end else begin
                        r_mid   <= 11'((r_lo + r_hi) >> 1);
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: r_state <= S_PAIR;
                S_PAIR: begin
                    if (r_sel1) begin
                        r_sel1 <= 1'b0;
                        r_v1 <= r_val_q; r_div_go <= 1'b1; r_state <= S_DIV;
                    end else if (r_in.query_wave < r_grid_q) begin
                        r_hi <= r_mid;
                        if (r_mid - r_lo <= 11'd1) begin
                            r_v1 <= r_val_q; r_div_go <= 1'b1; r_state <= S_DIV;
                        end else begin
                            r_mid <= 11'((r_lo + r_mid) >> 1); r_state <= S_PROBE;
                        end
                    end else begin
                        r_lo <= r_mid; r_g0 <= r_grid_q; r_v0 <= r_val_q;
                        if (r_hi - r_mid <= 11'd1) begin
                            r_mid <= r_hi; r_sel1 <= 1'b1; r_state <= S_PROBE;
                        end else begin
                            r_mid <= 11'((r_mid + r_hi) >> 1); r_state <= S_PROBE;
                        end
                    end
                end
                S_DIV: begin
                    r_div_go <= 1'b0;
                    if (w_div_done) begin
                        r_frac  <= w_quo;
                        r_lane  <= 2'd0;
                        r_mul_v <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mul_lane <= r_lane;
                    r_mul_v    <= 1'b1;
                    if (r_lane != 2'd3) r_lane <= r_lane + 2'd1;
                    if (r_mul_v) begin
                        case (r_mul_lane)
                            2'd0: r_res.width_v <= w_sat;
                            2'd1: r_res.shape_v <= w_sat;
                            2'd2: r_res.asym_v  <= w_sat;
                            default: begin
                                r_res.norm_v <= w_sat;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_sel1   <= 1'b0;
                        if (r_out.status == StQueryOk && r_in.command == CmdQuery) begin
                            r_out.width_out <= r_res.width_v;
                            r_out.shape_out <= r_res.shape_v;
                            r_out.asym_out  <= r_res.asym_v;
                            r_out.norm_out  <= r_res.norm_v;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
